// ===== rtl/woie_pkg.sv =====
// ----------------------------------------------------------------------------
// woie_pkg: shared types and constants of the incline estimator
// Sample and configuration structs, queue status, arctangent table.
// ----------------------------------------------------------------------------
package woie_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ASIN_STEPS_DEF = 16;
    localparam int W_BITS         = 16;
    localparam int W_ONE          = 65536;
    localparam int TBL_BITS       = 30;
    localparam int TBL_LEN        = 24;
    localparam int CNT_W          = 5;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = 1;
    localparam int Q_CNT_W        = 2;
    localparam int MUL_A_W        = 50;
    localparam int MUL_B_W        = 18;
    localparam int PROD_W         = 68;
    localparam int HUNDRED        = 100;
    localparam int ADDR_W         = 4;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WEIGHT = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_MINSTP = 2'd3;

    typedef struct packed {
        logic signed [31:0] wheel_rate;
        logic signed [31:0] altitude_in;
    } woie_item_t;

    typedef struct packed {
        logic               valid;
        logic [Q_CNT_W-1:0] count;
        woie_item_t         item;
    } woie_qstat_t;

    typedef struct packed {
        logic [16:0] smoothing_weight;
        logic [15:0] sample_period;
        logic [16:0] wheel_radius;
        logic [15:0] min_step;
    } woie_cfg_t;

    typedef struct packed {
        logic busy;
        logic loading;
    } woie_bstat_t;

    // atan(2^-i) in Q30
    function automatic logic [31:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd843314856;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525158;
            5'd4:    v = 32'd67021686;
            5'd5:    v = 32'd33543515;
            5'd6:    v = 32'd16775850;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194282;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048575;
            5'd11:   v = 32'd524287;
            5'd12:   v = 32'd262143;
            5'd13:   v = 32'd131071;
            5'd14:   v = 32'd65535;
            5'd15:   v = 32'd32767;
            5'd16:   v = 32'd16383;
            5'd17:   v = 32'd8191;
            5'd18:   v = 32'd4095;
            5'd19:   v = 32'd2047;
            5'd20:   v = 32'd1023;
            5'd21:   v = 32'd511;
            5'd22:   v = 32'd255;
            5'd23:   v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/woie_if.sv =====
// ----------------------------------------------------------------------------
// woie_if: sample and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface woie_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] wheel_rate;
    logic signed [31:0] altitude_in;

    modport source (output valid, output wheel_rate, output altitude_in, input ready);
    modport sink   (input valid, input wheel_rate, input altitude_in, output ready);
endinterface

interface woie_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] altitude_hundredths;
    logic signed [8:0]  incline_hundredths;
    logic [30:0]        distance_hundredths;
    logic signed [31:0] speed_hundredths;

    modport source (output valid, output altitude_hundredths, output incline_hundredths,
                    output distance_hundredths, output speed_hundredths, input ready);
    modport sink   (input valid, input altitude_hundredths, input incline_hundredths,
                    input distance_hundredths, input speed_hundredths, output ready);
endinterface

// ===== rtl/woie_front.sv =====
// ----------------------------------------------------------------------------
// woie_front: sample intake
// Takes sample transfers into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
module woie_front (
    input  logic                  clk,
    input  logic                  rst_n,
    woie_sample_if.sink           smp,
    input  logic                  pop,
    output woie_pkg::woie_qstat_t q_stat
);

    woie_pkg::woie_item_t                 mem_reg [woie_pkg::Q_DEPTH];
    logic [woie_pkg::Q_PTR_W-1:0]         wr_ptr_reg;
    logic [woie_pkg::Q_PTR_W-1:0]         rd_ptr_reg;
    logic [woie_pkg::Q_CNT_W-1:0]         cnt_reg;
    logic                                 push;

    assign smp.ready = (cnt_reg != woie_pkg::Q_CNT_W'(woie_pkg::Q_DEPTH));
    assign push      = smp.valid && smp.ready;

    assign q_stat.valid = (cnt_reg != '0);
    assign q_stat.count = cnt_reg;
    assign q_stat.item  = mem_reg[rd_ptr_reg];

    // pointers and fill count (depth is a power of two, pointers wrap)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg].wheel_rate  <= smp.wheel_rate;
            mem_reg[wr_ptr_reg].altitude_in <= smp.altitude_in;
        end
    end

endmodule

// ===== rtl/woie_back.sv =====
// ----------------------------------------------------------------------------
// woie_back: estimator sequencer
// Runs one sample through a shared multiplier, a restoring divider, a square
// root and a CORDIC arcsine, then converts the four results to hundredths.
// ----------------------------------------------------------------------------
module woie_back #(
    parameter int FRAC_BITS  = woie_pkg::FRAC_BITS_DEF,
    parameter int ASIN_STEPS = woie_pkg::ASIN_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  woie_pkg::woie_cfg_t   cfg,
    input  woie_pkg::woie_qstat_t q_stat,
    output logic                  q_pop,
    output woie_pkg::woie_bstat_t b_stat,
    woie_result_if.source         res
);

    localparam int F   = FRAC_BITS;
    localparam int PW  = woie_pkg::PROD_W;
    localparam int AW  = woie_pkg::MUL_A_W;
    localparam int BW  = woie_pkg::MUL_B_W;
    localparam int CW  = woie_pkg::CNT_W;
    localparam int NW  = 2 * F + 2;
    localparam int XW  = F + 4;
    localparam int QW  = F + 1;
    localparam int ZW  = 33;
    localparam int ZSH = woie_pkg::TBL_BITS - F;

    localparam logic signed [PW-1:0] RND_W = {{(PW-1){1'b0}}, 1'b1} << (woie_pkg::W_BITS-1);
    localparam logic signed [PW-1:0] RND_F = {{(PW-1){1'b0}}, 1'b1} << (F-1);
    localparam logic signed [ZW-1:0] RND_Z = {{(ZW-1){1'b0}}, 1'b1} << (ZSH-1);
    localparam logic [NW-1:0]        SQ_START = {{(NW-1){1'b0}}, 1'b1} << (2*F);
    localparam logic [CW-1:0]        LAST_BIT = CW'(F);
    localparam logic [CW-1:0]        LAST_COR = CW'(ASIN_STEPS-1);
    localparam logic [16:0]          W_ONE    = 17'(woie_pkg::W_ONE);
    localparam logic signed [PW-1:0] S32_MAX  = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] S32_MIN  = PW'(-64'sd2147483648);
    localparam logic signed [PW-1:0] INC_MAX  = PW'(158);
    localparam logic signed [PW-1:0] INC_MIN  = PW'(-158);
    localparam logic signed [AW:0]   SPD_MAX  = (AW+1)'(64'sd2147483647);
    localparam logic signed [AW:0]   SPD_MIN  = (AW+1)'(-64'sd2147483648);

    typedef enum logic [18:0] {
        ST_IDLE     = 19'b1 << 0,
        ST_MUL_ADV  = 19'b1 << 1,
        ST_ADV      = 19'b1 << 2,
        ST_MUL_GROW = 19'b1 << 3,
        ST_DIST     = 19'b1 << 4,
        ST_DIV      = 19'b1 << 5,
        ST_MUL_SQ   = 19'b1 << 6,
        ST_SQRT     = 19'b1 << 7,
        ST_CORDIC   = 19'b1 << 8,
        ST_ANG      = 19'b1 << 9,
        ST_MUL_INC  = 19'b1 << 10,
        ST_INC      = 19'b1 << 11,
        ST_MUL_GOAL = 19'b1 << 12,
        ST_GOAL     = 19'b1 << 13,
        ST_MUL_SPD  = 19'b1 << 14,
        ST_SPD      = 19'b1 << 15,
        ST_HMUL     = 19'b1 << 16,
        ST_HRES     = 19'b1 << 17,
        ST_OUT      = 19'b1 << 18
    } woie_state_t;

    woie_state_t state_reg, state_next;

    // estimator state
    logic signed [31:0] speed_reg, inc_reg, alt_last_reg;
    logic [47:0]        dist_reg;
    logic               first_reg;
    logic               ovalid_reg;

    // working registers
    logic [16:0]          w_reg;
    logic signed [31:0]   rate_reg, alt_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [32:0]   adv_reg;
    logic [32:0]          mag_reg, rem_reg;
    logic                 neg_reg, hneg_reg;
    logic [QW-1:0]        r_reg;
    logic [CW-1:0]        cnt_reg;
    logic [NW-1:0]        n_reg, root_reg, bit_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [AW-1:0] diff_reg;
    logic [1:0]           hsel_reg;
    logic signed [31:0]   ra_reg, rs_reg, oa_reg, os_reg;
    logic signed [8:0]    ri_reg, oi_reg;
    logic [30:0]          rd_reg, od_reg;

    // combinational helpers
    logic [16:0]          w_eff;
    logic signed [PW-1:0] w_rnd, f_rnd, sv;
    logic signed [AW-1:0] mul_a, hv, hmag;
    logic signed [BW-1:0] mul_b;
    logic signed [32:0]   rise;
    logic [32:0]          mag, adv_u, rem_sub;
    logic                 rem_ge, take_step, load;
    logic [NW-1:0]        sq_t, root_next;
    logic                 sq_ge;
    logic signed [XW-1:0] xs, ys, ry;
    logic signed [ZW-1:0] za, ang;
    logic [47:0]          dist_sat;
    logic [48:0]          dsum;
    logic signed [AW:0]   ssum;

    assign w_eff = first_reg ? W_ONE : ((cfg.smoothing_weight > W_ONE) ? W_ONE
                                                                        : cfg.smoothing_weight);
    assign w_rnd = (prod_reg + RND_W) >>> woie_pkg::W_BITS;
    assign f_rnd = (prod_reg + RND_F) >>> F;

    assign rise  = 33'(alt_reg) - 33'(alt_last_reg);
    assign mag   = rise[32] ? 33'(-rise) : 33'(rise);
    assign adv_u = adv_reg;
    assign take_step = (adv_reg > $signed({17'd0, cfg.min_step}));

    // divider step
    assign rem_ge  = (rem_reg >= adv_u);
    assign rem_sub = rem_ge ? (rem_reg - adv_u) : rem_reg;

    // square root step
    assign sq_t      = root_reg + bit_reg;
    assign sq_ge     = (n_reg >= sq_t);
    assign root_next = sq_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    // CORDIC step
    assign xs  = x_reg >>> cnt_reg;
    assign ys  = y_reg >>> cnt_reg;
    assign za  = $signed({1'b0, woie_pkg::atan_q30(cnt_reg)});
    assign ry  = $signed({{(XW-QW){1'b0}}, r_reg});
    assign ang = (z_reg + RND_Z) >>> ZSH;

    assign dsum     = {1'b0, dist_reg} + 49'(w_rnd[32:0]);
    assign dist_sat = dsum[48] ? {48{1'b1}} : dsum[47:0];
    assign ssum     = (AW+1)'(speed_reg) + (AW+1)'($signed(w_rnd[AW-1:0]));

    // value to convert to hundredths
    always_comb
    begin
        case (hsel_reg)
            2'd0:    hv = AW'(alt_reg);
            2'd1:    hv = AW'(inc_reg);
            2'd2:    hv = $signed({{(AW-48){1'b0}}, dist_reg});
            default: hv = AW'(speed_reg);
        endcase
    end
    assign hmag = hv[AW-1] ? -hv : hv;
    assign sv   = hneg_reg ? -f_rnd : f_rnd;

    // shared multiplier operands
    always_comb
    begin
        mul_a = AW'(speed_reg);
        mul_b = $signed({2'b00, cfg.sample_period});
        case (state_reg)
            ST_MUL_GROW:
            begin
                mul_a = AW'(adv_reg);
                mul_b = $signed({1'b0, w_reg});
            end
            ST_MUL_INC, ST_MUL_SPD:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, w_reg});
            end
            ST_MUL_GOAL:
            begin
                mul_a = AW'(rate_reg);
                mul_b = $signed({1'b0, cfg.wheel_radius});
            end
            ST_HMUL:
            begin
                mul_a = hmag;
                mul_b = BW'(woie_pkg::HUNDRED);
            end
            default:
            begin
                mul_a = AW'(speed_reg);
                mul_b = $signed({2'b00, cfg.sample_period});
            end
        endcase
    end

    assign load           = (state_reg == ST_OUT) && (!ovalid_reg || res.ready);
    assign q_pop          = (state_reg == ST_IDLE) && q_stat.valid;
    assign b_stat.busy    = (state_reg != ST_IDLE);
    assign b_stat.loading = load;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (q_stat.valid) state_next = ST_MUL_ADV;
            ST_MUL_ADV:  state_next = ST_ADV;
            ST_ADV:      state_next = ST_MUL_GROW;
            ST_MUL_GROW: state_next = take_step ? ST_DIST : ST_MUL_GOAL;
            ST_DIST:     state_next = (mag_reg <= adv_u) ? ST_DIV : ST_MUL_GOAL;
            ST_DIV:      if (cnt_reg == LAST_BIT) state_next = ST_MUL_SQ;
            ST_MUL_SQ:   state_next = ST_SQRT;
            ST_SQRT:     if (cnt_reg == LAST_BIT) state_next = ST_CORDIC;
            ST_CORDIC:   if (cnt_reg == LAST_COR) state_next = ST_ANG;
            ST_ANG:      state_next = ST_MUL_INC;
            ST_MUL_INC:  state_next = ST_INC;
            ST_INC:      state_next = ST_MUL_GOAL;
            ST_MUL_GOAL: state_next = ST_GOAL;
            ST_GOAL:     state_next = ST_MUL_SPD;
            ST_MUL_SPD:  state_next = ST_SPD;
            ST_SPD:      state_next = ST_HMUL;
            ST_HMUL:     state_next = ST_HRES;
            ST_HRES:     state_next = (hsel_reg == 2'd3) ? ST_OUT : ST_HMUL;
            ST_OUT:      if (load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control and estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            speed_reg    <= '0;
            dist_reg     <= '0;
            inc_reg      <= '0;
            alt_last_reg <= '0;
            first_reg    <= 1'b1;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIST)
                dist_reg <= dist_sat;
            if (state_reg == ST_INC)
                inc_reg <= inc_reg + $signed(w_rnd[31:0]);
            if (state_reg == ST_SPD)
            begin
                if (ssum > SPD_MAX)
                    speed_reg <= 32'sh7FFFFFFF;
                else if (ssum < SPD_MIN)
                    speed_reg <= 32'sh80000000;
                else
                    speed_reg <= ssum[31:0];
                alt_last_reg <= alt_reg;
                first_reg    <= 1'b0;
            end
            if (load)
                ovalid_reg <= 1'b1;
            else if (res.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                rate_reg <= q_stat.item.wheel_rate;
                alt_reg  <= q_stat.item.altitude_in;
                w_reg    <= w_eff;
            end
            ST_ADV:
            begin
                adv_reg <= w_rnd[32:0];
                mag_reg <= mag;
                neg_reg <= rise[32];
            end
            ST_DIST:
            begin
                rem_reg <= mag_reg;
                r_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= {rem_sub[31:0], 1'b0};
                r_reg   <= {r_reg[QW-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_MUL_SQ:
            begin
                n_reg    <= SQ_START - NW'(r_reg * r_reg);
                root_reg <= '0;
                bit_reg  <= SQ_START;
                cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                if (sq_ge)
                    n_reg <= n_reg - sq_t;
                root_reg <= root_next;
                bit_reg  <= bit_reg >> 2;
                if (cnt_reg == LAST_BIT)
                begin
                    x_reg   <= $signed(XW'(root_next));
                    y_reg   <= neg_reg ? -ry : ry;
                    z_reg   <= '0;
                    cnt_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_CORDIC:
            begin
                if (!y_reg[XW-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + za;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - za;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_ANG:
                diff_reg <= AW'(ang) - AW'(inc_reg);
            ST_GOAL:
                diff_reg <= $signed(f_rnd[AW-1:0]) - AW'(speed_reg);
            ST_SPD:
                hsel_reg <= 2'd0;
            ST_HMUL:
                hneg_reg <= hv[AW-1];
            ST_HRES:
            begin
                hsel_reg <= hsel_reg + 1'b1;
                case (hsel_reg)
                    2'd0:
                        ra_reg <= (sv > S32_MAX) ? 32'sh7FFFFFFF
                                : ((sv < S32_MIN) ? 32'sh80000000 : sv[31:0]);
                    2'd1:
                        ri_reg <= (sv > INC_MAX) ? INC_MAX[8:0]
                                : ((sv < INC_MIN) ? INC_MIN[8:0] : sv[8:0]);
                    2'd2:
                        rd_reg <= (sv > S32_MAX) ? {31{1'b1}} : sv[30:0];
                    default:
                        rs_reg <= (sv > S32_MAX) ? 32'sh7FFFFFFF
                                : ((sv < S32_MIN) ? 32'sh80000000 : sv[31:0]);
                endcase
            end
            default:
            begin
            end
        endcase
        if (load)
        begin
            oa_reg <= ra_reg;
            oi_reg <= ri_reg;
            od_reg <= rd_reg;
            os_reg <= rs_reg;
        end
    end

    assign res.valid               = ovalid_reg;
    assign res.altitude_hundredths = oa_reg;
    assign res.incline_hundredths  = oi_reg;
    assign res.distance_hundredths = od_reg;
    assign res.speed_hundredths    = os_reg;

endmodule

// ===== rtl/wheel_odometry_incline_estimator_core.sv =====
// ----------------------------------------------------------------------------
// wheel_odometry_incline_estimator_core: wheel odometry and incline estimator
// Turns wheel rate and barometric altitude samples into altitude, incline,
// distance and speed in hundredths.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one wheel rate and one altitude per transfer; result_ch
//   returns one result per sample, in order. The APB port holds the four
//   configuration registers at byte addresses 0, 4, 8 and 12; write them only
//   while no sample is in flight.
//   A sample whose step is long enough to update the incline passes through
//   the divider, the square root and the CORDIC loop, each one bit or one
//   step a cycle on one sequencer; a shorter step skips them. One sample is
//   worked on at a time.
//   A two-entry queue takes samples while the sequencer is busy, and the
//   result register holds a finished result while the receiver stalls; the
//   sequencer waits only when a second result is ready and the first is
//   still not taken.
//   Reset clears speed, distance, incline and last altitude, marks the next
//   sample as the first one, and loads the register defaults.
// ----------------------------------------------------------------------------
module wheel_odometry_incline_estimator_core #(
    parameter int FRAC_BITS  = woie_pkg::FRAC_BITS_DEF,
    parameter int ASIN_STEPS = woie_pkg::ASIN_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    woie_sample_if.sink                 sample_ch,
    woie_result_if.source               result_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [woie_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    woie_pkg::woie_cfg_t   cfg_reg;
    woie_pkg::woie_qstat_t q_stat;
    woie_pkg::woie_bstat_t b_stat;
    logic                  q_pop;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_weight <= 17'd32768;
            cfg_reg.sample_period    <= 16'd2621;
            cfg_reg.wheel_radius     <= 17'd18311;
            cfg_reg.min_step         <= 16'd262;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                woie_pkg::REG_WEIGHT: cfg_reg.smoothing_weight <= pwdata[16:0];
                woie_pkg::REG_PERIOD: cfg_reg.sample_period    <= pwdata[15:0];
                woie_pkg::REG_RADIUS: cfg_reg.wheel_radius     <= pwdata[16:0];
                woie_pkg::REG_MINSTP: cfg_reg.min_step         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            woie_pkg::REG_WEIGHT: prdata = {15'd0, cfg_reg.smoothing_weight};
            woie_pkg::REG_PERIOD: prdata = {16'd0, cfg_reg.sample_period};
            woie_pkg::REG_RADIUS: prdata = {15'd0, cfg_reg.wheel_radius};
            woie_pkg::REG_MINSTP: prdata = {16'd0, cfg_reg.min_step};
            default:              prdata = '0;
        endcase
    end

    woie_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .smp    (sample_ch),
        .pop    (q_pop),
        .q_stat (q_stat)
    );

    woie_back #(
        .FRAC_BITS  (FRAC_BITS),
        .ASIN_STEPS (ASIN_STEPS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .b_stat (b_stat),
        .res    (result_ch)
    );

    // queue never holds more than its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= woie_pkg::Q_CNT_W'(woie_pkg::Q_DEPTH))
        else $error("sample queue over depth");

    // intake stalls only on a full queue
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ch.ready |-> (q_stat.count == woie_pkg::Q_CNT_W'(woie_pkg::Q_DEPTH)))
        else $error("intake stalled with room in queue");

    // sequencer takes a sample only when idle and one is queued
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_stat.valid && !b_stat.busy))
        else $error("pop while busy or queue empty");

    // a new result appears only after the sequencer loaded it
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_ch.valid) |-> $past(b_stat.loading))
        else $error("result valid without load");

endmodule

// ===== tb/sv/tb_wheel_odometry_incline_estimator_core.sv =====
// ----------------------------------------------------------------------------
// tb_wheel_odometry_incline_estimator_core: self-checking bench of the estimator
// Drives wheel rate and altitude samples over valid/ready with random gaps and
// stalls, programs the four registers over APB between phases, and compares
// every result with a cycle-free prediction of altitude, incline, distance
// and speed.
// ----------------------------------------------------------------------------
module tb_wheel_odometry_incline_estimator_core;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 200;
    localparam longint DIST_MAX    = (64'sd1 <<< 48) - 1;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam longint S32_MAX     = 64'sd2147483647;

    typedef struct packed {
        logic signed [31:0] altitude;
        logic signed [8:0]  incline;
        logic [30:0]        distance;
        logic signed [31:0] speed;
    } odo_result_t;

    // atan(2^-i), Q30
    localparam longint ATAN_Q30 [0:15] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [woie_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    woie_sample_if s_ch ();
    woie_result_if r_ch ();

    wheel_odometry_incline_estimator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (s_ch),
        .result_ch (r_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // mirrored configuration and estimator state
    longint          cfg_weight, cfg_period, cfg_radius, cfg_min_step;
    longint          est_speed, est_incline, est_alt_last;
    longint unsigned est_distance;
    bit              est_first;

    odo_result_t expected_results [$];
    int          error_count;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------------
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint to_hundredths(input longint v);
        longint mag;
        longint q;
        mag = (v < 0 ? -v : v) * 100;
        q   = (mag + 32768) >>> 16;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // asin via CORDIC vectoring on (sqrt(1-r^2), r)
    function automatic longint arcsine_q16(input longint r);
        longint x, y, z, xn;
        x = int_sqrt(longint'(65536) * 65536 - r * r);
        y = r;
        z = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_Q30[i];
            end
            else
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_Q30[i];
            end
            x = xn;
        end
        return round_shift(z, 14);
    endfunction

    // Advance the estimator by one sample and produce its result
    function automatic odo_result_t estimate_step(input longint rate, input longint alt);
        odo_result_t res;
        longint w, adv, grow, rise, mag, r, ang, goal;
        w   = est_first ? 65536 : (cfg_weight > 65536 ? 65536 : cfg_weight);
        adv = round_shift(est_speed * cfg_period, 16);
        if (adv > cfg_min_step)
        begin
            grow = round_shift(w * adv, 16);
            if (longint'(grow) > DIST_MAX - longint'(est_distance))
                est_distance = DIST_MAX;
            else
                est_distance = est_distance + grow;
            rise = alt - est_alt_last;
            mag  = rise < 0 ? -rise : rise;
            if (mag <= adv)
            begin
                r   = (mag <<< 16) / adv;
                ang = arcsine_q16(rise < 0 ? -r : r);
                est_incline = est_incline + round_shift(w * (ang - est_incline), 16);
            end
        end
        goal = round_shift(rate * cfg_radius, 16);
        est_speed = clamp(est_speed + round_shift(w * (goal - est_speed), 16),
                          S32_MIN, S32_MAX);
        est_alt_last = alt;
        est_first    = 1'b0;
        res.altitude = 32'(clamp(to_hundredths(alt), S32_MIN, S32_MAX));
        res.incline  = 9'(clamp(to_hundredths(est_incline), -158, 158));
        res.distance = 31'(clamp(to_hundredths(longint'(est_distance)), 0, S32_MAX));
        res.speed    = 32'(clamp(to_hundredths(est_speed), S32_MIN, S32_MAX));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Bus and channel tasks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        error_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= woie_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            woie_pkg::REG_WEIGHT: cfg_weight   = longint'(value & 32'h1FFFF);
            woie_pkg::REG_PERIOD: cfg_period   = longint'(value & 32'hFFFF);
            woie_pkg::REG_RADIUS: cfg_radius   = longint'(value & 32'h1FFFF);
            woie_pkg::REG_MINSTP: cfg_min_step = longint'(value & 32'hFFFF);
            default: ;
        endcase
    endtask

    task automatic program_all(input logic [31:0] w, input logic [31:0] p,
                               input logic [31:0] rad, input logic [31:0] ms);
        write_reg(woie_pkg::REG_WEIGHT, w);
        write_reg(woie_pkg::REG_PERIOD, p);
        write_reg(woie_pkg::REG_RADIUS, rad);
        write_reg(woie_pkg::REG_MINSTP, ms);
    endtask

    task automatic wait_drained();
        s_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one sample transfer; valid is left high for a back-to-back follower
    task automatic send_sample(input logic [31:0] rate, input logic [31:0] alt);
        while ($urandom_range(99) < idle_pct)
        begin
            s_ch.valid <= 1'b0;
            @(posedge clk);
        end
        s_ch.valid       <= 1'b1;
        s_ch.wheel_rate  <= rate;
        s_ch.altitude_in <= alt;
        @(posedge clk);
        while (!s_ch.ready)
            @(posedge clk);
        expected_results.push_back(estimate_step(longint'(signed'(rate)),
                                                 longint'(signed'(alt))));
    endtask

    // altitude step that mostly stays within the coming advance
    function automatic logic [31:0] next_altitude();
        longint adv, d;
        adv = round_shift(est_speed * cfg_period, 16);
        if (adv < 1)
            adv = 1;
        if (adv > 1000000)
            adv = 1000000;
        d = longint'($urandom_range(32'(2 * adv))) - adv;
        if ($urandom_range(9) == 0)
            d = d * 3;
        return 32'(clamp(est_alt_last + d, S32_MIN, S32_MAX));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // first sample: weight one, zero advance
        send_sample(32'sd655360, 32'sd100000);
        send_sample(32'sd655360, 32'sd100500);
        // climb then descend within the advance
        send_sample(32'sd655360, 32'sd103000);
        send_sample(32'sd655360, 32'sd100000);
        // ratio beyond one: incline held
        send_sample(32'sd655360, 32'sd900000);
        // pause until everything is out
        wait_drained();
        // altitude extremes
        send_sample(32'sd655360, 32'h7FFFFFFF);
        send_sample(32'sd655360, 32'h80000000);
        send_sample(32'sd0, 32'sd0);
        // rate extremes
        send_sample(32'h7FFFFFFF, 32'sd0);
        send_sample(32'h7FFFFFFF, 32'sd0);
        send_sample(32'h80000000, 32'hFFFFFFFF);
        send_sample(32'h80000000, 32'sd0);
        send_sample(32'sd0, 32'sd0);
        wait_drained();
        // weight above one, largest radius and period, no minimum step
        program_all(32'h1FFFF, 32'hFFFF, 32'h1FFFF, 32'd0);
        send_sample(32'sd300000, 32'sd0);
        send_sample(32'sd300000, 32'sd400000);
        send_sample(32'sd300000, -32'sd400000);
        wait_drained();
        // zero period: advance always zero
        program_all(32'd0, 32'd0, 32'd1, 32'hFFFF);
        send_sample(32'sd655360, 32'sd50000);
        send_sample(32'sd655360, 32'sd60000);
        wait_drained();
        // out-of-range bits are masked
        program_all(32'hFFFF_8000, 32'hABCD_1000, 32'hFFFE_4787, 32'h1234_0106);
        send_sample(32'sd655360, 32'sd60100);
        send_sample(32'sd655360, 32'sd60200);
        wait_drained();
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        logic [31:0] rate;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
            begin
                rate = $urandom_range(3000000);
                if ($urandom_range(15) == 0)
                    rate = -rate;
                send_sample(rate, next_altitude());
            end
            else
                send_sample($urandom, $urandom);
        end
        wait_drained();
    endtask

    task automatic test_random();
        program_all(32768, 2621, 18311, 262);
        test_random_phase(150, 0, 0);
        program_all(65536, 65535, 131071, 65535);
        test_random_phase(150, 86, 0);
        program_all(0, 1, 1, 0);
        test_random_phase(50, 0, 86);
        program_all($urandom_range(65536), $urandom_range(65535, 1),
                    $urandom_range(131071, 1), $urandom_range(65535));
        test_random_phase(100, 0, 86);
        program_all($urandom_range(65536, 20000), $urandom_range(8000, 1000),
                    $urandom_range(40000, 5000), $urandom_range(2000));
        test_random_phase(150, 13, 13);
    endtask

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        odo_result_t want;
        r_ch.ready <= ($urandom_range(99) >= stall_pct);
        if ((s_ch.valid && s_ch.ready) || (r_ch.valid && r_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        if (rst_n && r_ch.valid && r_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (r_ch.altitude_hundredths !== want.altitude)
                    report_mismatch("altitude", r_ch.altitude_hundredths, want.altitude);
                if (r_ch.incline_hundredths !== want.incline)
                    report_mismatch("incline", r_ch.incline_hundredths, want.incline);
                if (r_ch.distance_hundredths !== want.distance)
                    report_mismatch("distance", r_ch.distance_hundredths, want.distance);
                if (r_ch.speed_hundredths !== want.speed)
                    report_mismatch("speed", r_ch.speed_hundredths, want.speed);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        s_ch.valid       = 1'b0;
        s_ch.wheel_rate  = '0;
        s_ch.altitude_in = '0;
        r_ch.ready       = 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        quiet_cycles     = 0;
        error_count      = 0;
        cfg_weight       = 32768;
        cfg_period       = 2621;
        cfg_radius       = 18311;
        cfg_min_step     = 262;
        est_speed        = 0;
        est_distance     = 0;
        est_incline      = 0;
        est_alt_last     = 0;
        est_first        = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/woie_pkg.sv
rtl/woie_if.sv
rtl/woie_front.sv
rtl/woie_back.sv
rtl/wheel_odometry_incline_estimator_core.sv
tb/sv/tb_wheel_odometry_incline_estimator_core.sv
